// ===== rtl/core/rpe_pkg.sv =====
// Shared types, constants and build-time table functions for the rotary position embedding.
`default_nettype none

package rpe_pkg;

	// Default values of the top-level parameters.
	localparam int HEAD_SIZE_DEF       = 128;
	localparam int MAX_POSITION_DEF    = 32768;
	localparam int ROTATION_STAGES_DEF = 16;

	// Field widths.
	localparam int POS_W = 15;
	localparam int IDX_W = 6;
	localparam int VAL_W = 16;
	localparam int FRAC_W = 12;

	// Rotation datapath widths: values scaled by 2^12 plus CORDIC growth and sign.
	localparam int DW = 31;
	localparam int ZW = 32;
	localparam int AW = 32;
	localparam int GW = 32;
	localparam int PW = 64;

	// Gain product carries Q31 gain and the 2^12 input scale.
	localparam int FINISH_SH = 43;

	localparam logic [AW-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [AW-1:0] HALF_TURN    = 32'h8000_0000;

	localparam logic [63:0] LOG2_BASE_Q32  = 64'd85605435163;
	localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565275;

	typedef logic [AW-1:0] freq_rom_t [1 << IDX_W];

	// One beat moving along the rotation chain.
	typedef struct packed {
		logic                 valid;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_beat_t;

	// Restoring division, evaluated only while building constants.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r = '0;
		rem = v;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Frequency of one pair index in turns per position, Q32.
	function automatic logic [AW-1:0] freq_turns(input int idx, input int vec_len);
		logic [63:0] e;
		logic [63:0] n;
		logic [31:0] f;
		logic [63:0] r;
		logic [63:0] m;
		logic [63:0] res;
		e = udiv64(64'(2 * idx) * LOG2_BASE_Q32, 64'(vec_len));
		n = e >> 32;
		f = e[31:0];
		r = 64'd1 << 30;
		m = 64'd1 << 31;
		for (int k = 1; k <= 32; k++) begin
			r = isqrt64(r << 31);
			if (f[32 - k])
				m = (m * r) >> 31;
		end
		if (n >= 64'd32)
			res = '0;
		else
			res = ((m * INV_TWO_PI_Q32) >> 31) >> n;
		return res[AW-1:0];
	endfunction

	function automatic freq_rom_t build_freq_rom(input int vec_len);
		freq_rom_t rom;
		for (int i = 0; i < (1 << IDX_W); i++)
			rom[i] = freq_turns(i, vec_len);
		return rom;
	endfunction

	// Arctangent of 2^-k in turns, Q32.
	function automatic logic [ZW-1:0] atan_turns(input int k);
		logic [63:0] s;
		logic [63:0] term;
		logic [63:0] res;
		int          sh;
		s = '0;
		if (k == 0) begin
			res = 64'd1 << 29;
		end else begin
			for (int j = 0; j < 32; j++) begin
				sh = k * (2 * j + 1);
				if (sh <= 62) begin
					term = udiv64(64'd1 << (62 - sh), 64'(2 * j + 1));
					if (j % 2 == 1)
						s = s - term;
					else
						s = s + term;
				end
			end
			res = ((s >> 32) * INV_TWO_PI_Q32
				+ (((s & 64'hFFFF_FFFF) * INV_TWO_PI_Q32) >> 32)) >> 30;
		end
		return res[ZW-1:0];
	endfunction

	// CORDIC gain compensation 1/prod(sqrt(1 + 4^-k)), Q31.
	function automatic logic [GW-1:0] gain_q31(input int stages);
		logic [63:0] p;
		logic [63:0] res;
		p = 64'd1 << 62;
		for (int k = 0; k < stages; k++)
			p = p - udiv64(p, (64'd1 << (2 * k)) + 64'd1);
		res = isqrt64(p);
		return res[GW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rpe_angle.sv =====
// Front end: frequency ROM, angle product, quadrant fold and input scaling.
`default_nettype none

module rpe_angle #(
	parameter int HEAD_SIZE    = rpe_pkg::HEAD_SIZE_DEF,
	parameter int MAX_POSITION = rpe_pkg::MAX_POSITION_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire logic                              valid,
	input  wire logic        [rpe_pkg::POS_W-1:0]  position,
	input  wire logic        [rpe_pkg::IDX_W-1:0]  pair_index,
	input  wire logic signed [rpe_pkg::VAL_W-1:0]  first_in,
	input  wire logic signed [rpe_pkg::VAL_W-1:0]  second_in,
	output rpe_pkg::rot_beat_t                     beat
);
	import rpe_pkg::*;

	localparam freq_rom_t FREQ_ROM = build_freq_rom(HEAD_SIZE);

	logic                    valid_s1, valid_s2, valid_s3;
	logic        [POS_W-1:0] pos_s1;
	logic        [AW-1:0]    freq_s1;
	logic signed [VAL_W-1:0] x_s1, y_s1, x_s2, y_s2;
	logic        [AW-1:0]    ang_s2;
	logic signed [DW-1:0]    x_s3, y_s3;
	logic signed [ZW-1:0]    z_s3;

	logic        [POS_W-1:0]    pos_clamped;
	logic        [POS_W+AW-1:0] prod;
	logic        [AW-1:0]       ang_sum;
	logic                       flip;
	logic signed [DW-1:0]       xs, ys;

	always_comb begin
		if (32'(position) >= 32'(MAX_POSITION))
			pos_clamped = POS_W'(MAX_POSITION - 1);
		else
			pos_clamped = position;
		prod = (POS_W+AW)'(pos_s1) * (POS_W+AW)'(freq_s1);
		ang_sum = ang_s2 + QUARTER_TURN;
		flip = ang_sum[AW-1];
		xs = {{(DW-VAL_W-FRAC_W){x_s2[VAL_W-1]}}, x_s2, {FRAC_W{1'b0}}};
		ys = {{(DW-VAL_W-FRAC_W){y_s2[VAL_W-1]}}, y_s2, {FRAC_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= pos_clamped;
			freq_s1 <= FREQ_ROM[pair_index];
			x_s1 <= first_in;
			y_s1 <= second_in;
			ang_s2 <= prod[AW-1:0];
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			if (flip) begin
				x_s3 <= -xs;
				y_s3 <= -ys;
				z_s3 <= signed'(ang_s2 + HALF_TURN);
			end else begin
				x_s3 <= xs;
				y_s3 <= ys;
				z_s3 <= signed'(ang_s2);
			end
		end
	end

	assign beat = {valid_s3, x_s3, y_s3, z_s3};

endmodule

`default_nettype wire

// ===== rtl/core/rpe_cell.sv =====
// One CORDIC rotation cell: fixed shift, fixed arctangent, one register stage.
`default_nettype none

module rpe_cell #(
	parameter int                        STAGE = 0,
	parameter logic [rpe_pkg::ZW-1:0]    ATAN  = '0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  rpe_pkg::rot_beat_t prev,
	output rpe_pkg::rot_beat_t next
);
	import rpe_pkg::*;

	logic                 valid_q;
	logic signed [DW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [DW-1:0] dx, dy;

	assign dx = prev.y >>> STAGE;
	assign dy = prev.x >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= prev.valid;
	end

	// Rotate toward zero residual angle.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (!prev.z[ZW-1]) begin
				x_q <= prev.x - dx;
				y_q <= prev.y + dy;
				z_q <= prev.z - signed'(ATAN);
			end else begin
				x_q <= prev.x + dx;
				y_q <= prev.y - dy;
				z_q <= prev.z + signed'(ATAN);
			end
		end
	end

	assign next = {valid_q, x_q, y_q, z_q};

endmodule

`default_nettype wire

// ===== rtl/core/rpe_gain.sv =====
// Back end: gain compensation, round half up and saturation to Q3.12.
`default_nettype none

module rpe_gain #(
	parameter logic [rpe_pkg::GW-1:0] GAIN = '0
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             adv,
	input  rpe_pkg::rot_beat_t                    beat,
	output logic                                  valid,
	output logic signed [rpe_pkg::VAL_W-1:0]      first_out,
	output logic signed [rpe_pkg::VAL_W-1:0]      second_out
);
	import rpe_pkg::*;

	localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (FINISH_SH - 1);
	localparam logic signed [PW-1:0] MAX_V = PW'(32767);
	localparam logic signed [PW-1:0] MIN_V = -PW'(32768);

	logic                    valid_s1, valid_s2;
	logic signed [PW-1:0]    px_s1, py_s1;
	logic signed [VAL_W-1:0] fx_s2, fy_s2;
	logic signed [PW-1:0]    gain_ext;

	function automatic logic signed [VAL_W-1:0] finish(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] r;
		r = (p + ROUND) >>> FINISH_SH;
		if (r > MAX_V)
			r = MAX_V;
		else if (r < MIN_V)
			r = MIN_V;
		return r[VAL_W-1:0];
	endfunction

	assign gain_ext = signed'({{(PW-GW){1'b0}}, GAIN});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= beat.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= signed'({{(PW-DW){beat.x[DW-1]}}, beat.x}) * gain_ext;
			py_s1 <= signed'({{(PW-DW){beat.y[DW-1]}}, beat.y}) * gain_ext;
			fx_s2 <= finish(px_s1);
			fy_s2 <= finish(py_s1);
		end
	end

	assign valid = valid_s2;
	assign first_out = fx_s2;
	assign second_out = fy_s2;

endmodule

`default_nettype wire

// ===== rtl/core/rotary_position_embedding.sv =====
// Top level of the rotary position embedding: angle front end, CORDIC cell row, gain back end.
//
//   channel   beat fields                                    handshake
//   item      position, pair_index, first_in, second_in      item_valid / item_ready
//   result    first_out, second_out                          result_valid / result_ready
//
// One beat is accepted per cycle while item_ready is high, and one result leaves per cycle
// when the result side takes it. The pipeline has three front-end stages (ROM read, angle
// product, quadrant fold), a register stage in each CORDIC cell and two back-end stages.
// Reset clears only the valid flags along the pipeline; the data registers are not reset.
// The whole pipeline advances together; when a result waits untaken, every stage holds
// and item_ready drops, while an empty output slot keeps it moving.
`default_nettype none

module rotary_position_embedding #(
	parameter int HEAD_SIZE       = rpe_pkg::HEAD_SIZE_DEF,
	parameter int MAX_POSITION    = rpe_pkg::MAX_POSITION_DEF,
	parameter int ROTATION_STAGES = rpe_pkg::ROTATION_STAGES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_ready,
	input  wire logic        [rpe_pkg::POS_W-1:0] position,
	input  wire logic        [rpe_pkg::IDX_W-1:0] pair_index,
	input  wire logic signed [rpe_pkg::VAL_W-1:0] first_in,
	input  wire logic signed [rpe_pkg::VAL_W-1:0] second_in,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output logic signed [rpe_pkg::VAL_W-1:0]      first_out,
	output logic signed [rpe_pkg::VAL_W-1:0]      second_out
);
	import rpe_pkg::*;

	// Gain of the whole cell row, compensated in one multiply at the end.
	localparam logic [GW-1:0] GAIN = gain_q31(ROTATION_STAGES);

	logic      adv;
	rot_beat_t chain [ROTATION_STAGES+1];

	// The pipeline moves whenever the output slot is empty or being drained.
	assign adv = !result_valid || result_ready;
	assign item_ready = adv;

	// Looks up the pair frequency, forms the angle mod one turn, and folds it into
	// the half turn around zero by negating the vector when needed.
	rpe_angle #(
		.HEAD_SIZE    (HEAD_SIZE),
		.MAX_POSITION (MAX_POSITION)
	) u_angle (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid      (item_valid),
		.position   (position),
		.pair_index (pair_index),
		.first_in   (first_in),
		.second_in  (second_in),
		.beat       (chain[0])
	);

	// Each cell applies one micro-rotation and hands the vector and the remaining
	// angle, registered, to its neighbor.
	for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_cell
		rpe_cell #(
			.STAGE (k),
			.ATAN  (atan_turns(k))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.prev   (chain[k]),
			.next   (chain[k+1])
		);
	end

	// Scales out the CORDIC gain, rounds and saturates to Q3.12.
	rpe_gain #(
		.GAIN (GAIN)
	) u_gain (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.beat       (chain[ROTATION_STAGES]),
		.valid      (result_valid),
		.first_out  (first_out),
		.second_out (second_out)
	);

endmodule

`default_nettype wire
